// ===== hdl/hlf_pkg.sv =====
// Shared types, constants and saturating log arithmetic for the forward recursion block.
package hlf_pkg;

    typedef enum logic [1:0] {
        CMD_OBSERVE    = 2'd0,
        CMD_LOAD_INIT  = 2'd1,
        CMD_LOAD_TRANS = 2'd2,
        CMD_LOAD_EMIS  = 2'd3
    } cmd_t;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 3;

    localparam logic REG_STATES   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    localparam logic signed [31:0] LSE_CORR [16] = '{
        32'sd45426, 32'sd31069, 32'sd20530, 32'sd13200,
        32'sd8318,  32'sd5170,  32'sd3184,  32'sd1950,
        32'sd1189,  32'sd724,   32'sd440,   32'sd267,
        32'sd162,   32'sd98,    32'sd60,    32'sd36
    };

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] lse2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] dab;
        logic signed [32:0] dba;
        logic [32:0] d;
        logic signed [31:0] m;
        dab = {a[31], a} - {b[31], b};
        dba = {b[31], b} - {a[31], a};
        if (a > b)
        begin
            m = a;
            d = dab;
        end
        else
        begin
            m = b;
            d = dba;
        end
        if (d[32:19] == 14'd0)
        begin
            return sadd(m, LSE_CORR[d[18:15]]);
        end
        return m;
    endfunction

endpackage

// ===== hdl/hmm_log_forward_multichannel.sv =====
// Log-domain forward recursion for a multichannel hidden Markov model.
// Load beats (tuser command 1..3) write the initial, transition or emission table. An
// observation beat produces one result beat per state in use, in state order, tlast on
// the final one. Without a start flag each state walks every predecessor through the
// transition and forward-value memories with one shared log-sum-exp adder, then adds the
// emission memory once per channel; with it, the initial value replaces the predecessor
// walk. Input is accepted only between observations; the output register lets the next
// state proceed while a result beat waits.
module hmm_log_forward_multichannel #(
    parameter int STATES   = 16,
    parameter int SYMBOLS  = 16,
    parameter int CHANNELS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sym_0, sym_1, sym_2, sym_3, row_index, col_index, channel_index, table_value, zero pad
    input  logic [hlf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command, start_sequence
    input  logic [hlf_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // state_number, log_alpha, zero pad
    output logic [hlf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hlf_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import hlf_pkg::*;

    localparam int SW  = $clog2(STATES);
    localparam int TAW = $clog2(STATES * STATES);
    localparam int EAW = $clog2(CHANNELS * STATES * SYMBOLS);
    localparam int PAW = $clog2(2 * STATES);
    localparam int LW  = (SW > 5) ? SW : 5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOP, ST_LDRAIN, ST_EMIS, ST_EDRAIN, ST_EMIT
    } state_t;

    typedef enum logic [1:0] { K_TERM, K_INIT, K_EMIS } kind_t;

    state_t             state_reg;
    kind_t              rd_kind_reg;
    logic               rd_v_reg;
    logic               rd_first_reg;
    logic               t_v_reg;
    logic               t_first_reg;
    logic signed [31:0] term_reg;
    logic signed [31:0] acc_reg;
    logic [SW-1:0]      i_reg;
    logic [SW-1:0]      j_reg;
    logic [1:0]         r_reg;
    logic               bank_reg;
    logic               start_reg;
    logic [3:0]         sym_reg [4];
    logic [4:0]         states_in_use_reg;
    logic [2:0]         channels_in_use_reg;
    logic               out_valid_reg;
    logic [3:0]         out_state_reg;
    logic signed [31:0] out_alpha_reg;
    logic               out_last_reg;

    cmd_t               cmd;
    logic               in_fire;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [1:0]         chan;
    logic signed [31:0] value;
    logic [3:0]         sym_in [4];
    logic [3:0]         sym_mod [4];
    logic [4:0]         ns_m1;
    logic [2:0]         nc_m1;
    logic               last_j;
    logic               last_i;
    logic               emit_go;

    logic               init_we;
    logic               trans_we;
    logic               emis_we;
    logic [TAW-1:0]     trans_waddr;
    logic [TAW-1:0]     trans_raddr;
    logic [EAW-1:0]     emis_waddr;
    logic [EAW-1:0]     emis_raddr;
    logic [PAW-1:0]     prev_waddr;
    logic [PAW-1:0]     prev_raddr;
    logic [31:0]        init_rdata;
    logic [31:0]        trans_rdata;
    logic [31:0]        emis_rdata;
    logic [31:0]        prev_rdata;

    assign cmd     = cmd_t'(s_tuser[1:0]);
    assign in_fire = s_tvalid && s_tready;
    assign row     = s_tdata[19:16];
    assign col     = s_tdata[23:20];
    assign chan    = s_tdata[25:24];
    assign value   = s_tdata[57:26];
    assign sym_in[0] = s_tdata[3:0];
    assign sym_in[1] = s_tdata[7:4];
    assign sym_in[2] = s_tdata[11:8];
    assign sym_in[3] = s_tdata[15:12];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sym_mod[c] = sym_in[c];
            for (int s = 0; s < 8; s++)
            begin
                if (32'(sym_mod[c]) >= SYMBOLS)
                begin
                    sym_mod[c] = 4'(32'(sym_mod[c]) - SYMBOLS);
                end
            end
        end
    end

    assign ns_m1   = states_in_use_reg - 5'd1;
    assign nc_m1   = channels_in_use_reg - 3'd1;
    assign last_j  = LW'(j_reg) == LW'(ns_m1);
    assign last_i  = LW'(i_reg) == LW'(ns_m1);
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign init_we  = in_fire && (cmd == CMD_LOAD_INIT) && (32'(row) < STATES);
    assign trans_we = in_fire && (cmd == CMD_LOAD_TRANS) && (32'(row) < STATES)
                      && (32'(col) < STATES);
    assign emis_we  = in_fire && (cmd == CMD_LOAD_EMIS) && (32'(chan) < CHANNELS)
                      && (32'(row) < STATES) && (32'(col) < SYMBOLS);

    assign trans_waddr = TAW'(32'(row) * STATES + 32'(col));
    assign trans_raddr = TAW'(32'(j_reg) * STATES + 32'(i_reg));
    assign emis_waddr  = EAW'((32'(chan) * STATES + 32'(row)) * SYMBOLS + 32'(col));
    assign emis_raddr  = EAW'((32'(r_reg) * STATES + 32'(i_reg)) * SYMBOLS
                              + 32'(sym_reg[r_reg]));
    assign prev_raddr  = PAW'(32'(bank_reg) * STATES + 32'(j_reg));
    assign prev_waddr  = PAW'(32'(!bank_reg) * STATES + 32'(i_reg));

    hlf_ram #(.WIDTH(32), .DEPTH(STATES)) u_init_ram (
        .clk(clk), .we(init_we), .waddr(SW'(row)), .wdata(value),
        .raddr(i_reg), .rdata(init_rdata)
    );

    hlf_ram #(.WIDTH(32), .DEPTH(STATES * STATES)) u_trans_ram (
        .clk(clk), .we(trans_we), .waddr(trans_waddr), .wdata(value),
        .raddr(trans_raddr), .rdata(trans_rdata)
    );

    hlf_ram #(.WIDTH(32), .DEPTH(CHANNELS * STATES * SYMBOLS)) u_emis_ram (
        .clk(clk), .we(emis_we), .waddr(emis_waddr), .wdata(value),
        .raddr(emis_raddr), .rdata(emis_rdata)
    );

    hlf_ram #(.WIDTH(32), .DEPTH(2 * STATES)) u_prev_ram (
        .clk(clk), .we(emit_go), .waddr(prev_waddr), .wdata(acc_reg),
        .raddr(prev_raddr), .rdata(prev_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            rd_v_reg            <= 1'b0;
            t_v_reg             <= 1'b0;
            i_reg               <= '0;
            j_reg               <= '0;
            r_reg               <= '0;
            bank_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
            states_in_use_reg   <= 5'((STATES < 16) ? STATES : 16);
            channels_in_use_reg <= 3'd1;
        end
        else
        begin
            t_v_reg      <= rd_v_reg && (rd_kind_reg == K_TERM);
            t_first_reg  <= rd_first_reg;
            term_reg     <= sadd(prev_rdata, trans_rdata);

            if (rd_v_reg && (rd_kind_reg == K_INIT))
            begin
                acc_reg <= init_rdata;
            end
            else if (rd_v_reg && (rd_kind_reg == K_EMIS))
            begin
                acc_reg <= sadd(acc_reg, emis_rdata);
            end
            else if (t_v_reg)
            begin
                acc_reg <= t_first_reg ? term_reg : lse2(acc_reg, term_reg);
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_STATES)
                begin
                    if (pwdata[4:0] == 5'd0)
                    begin
                        states_in_use_reg <= 5'd1;
                    end
                    else if (32'(pwdata[4:0]) > STATES)
                    begin
                        states_in_use_reg <= 5'(STATES);
                    end
                    else
                    begin
                        states_in_use_reg <= pwdata[4:0];
                    end
                end
                else
                begin
                    if (pwdata[2:0] == 3'd0)
                    begin
                        channels_in_use_reg <= 3'd1;
                    end
                    else if (32'(pwdata[2:0]) > CHANNELS)
                    begin
                        channels_in_use_reg <= 3'(CHANNELS);
                    end
                    else
                    begin
                        channels_in_use_reg <= pwdata[2:0];
                    end
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    rd_v_reg <= 1'b0;
                    if (in_fire && (cmd == CMD_OBSERVE))
                    begin
                        start_reg <= s_tuser[2];
                        for (int c = 0; c < 4; c++)
                        begin
                            sym_reg[c] <= sym_mod[c];
                        end
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP:
                begin
                    rd_v_reg <= 1'b1;
                    if (start_reg)
                    begin
                        rd_kind_reg  <= K_INIT;
                        rd_first_reg <= 1'b0;
                        state_reg    <= ST_LDRAIN;
                    end
                    else
                    begin
                        rd_kind_reg  <= K_TERM;
                        rd_first_reg <= (j_reg == '0);
                        if (last_j)
                        begin
                            j_reg     <= '0;
                            state_reg <= ST_LDRAIN;
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_LDRAIN:
                begin
                    rd_v_reg <= 1'b0;
                    if (!rd_v_reg && !t_v_reg)
                    begin
                        r_reg     <= '0;
                        state_reg <= ST_EMIS;
                    end
                end
                ST_EMIS:
                begin
                    rd_v_reg     <= 1'b1;
                    rd_kind_reg  <= K_EMIS;
                    rd_first_reg <= 1'b0;
                    if (3'(r_reg) == nc_m1)
                    begin
                        state_reg <= ST_EDRAIN;
                    end
                    else
                    begin
                        r_reg <= r_reg + 2'd1;
                    end
                end
                ST_EDRAIN:
                begin
                    rd_v_reg <= 1'b0;
                    if (!rd_v_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    rd_v_reg <= 1'b0;
                    if (emit_go)
                    begin
                        out_state_reg <= 4'(i_reg);
                        out_alpha_reg <= acc_reg;
                        out_last_reg  <= last_i;
                        if (last_i)
                        begin
                            i_reg     <= '0;
                            bank_reg  <= !bank_reg;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_LOOP;
                        end
                    end
                end
                default:
                begin
                    rd_v_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_alpha_reg, out_state_reg};
    assign m_tlast  = out_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CHANNELS) ? {29'd0, channels_in_use_reg}
                                                 : {27'd0, states_in_use_reg};
endmodule

// ===== hdl/hlf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/hlf_checker.sv =====
// Port-level checks for the forward recursion block, bound to the top level.
module hlf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [hlf_pkg::IN_TUSER_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [hlf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import hlf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_obs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[1:0] == CMD_OBSERVE) |=> !s_tready)
        else $error("input still ready after an observation");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[1:0] != CMD_OBSERVE) |=> s_tready)
        else $error("load beat stalled the input");
endmodule

bind hmm_log_forward_multichannel hlf_checker u_hlf_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ===== tb/hmm_log_forward_multichannel_tb.sv =====
// Self-checking testbench for the multichannel log-domain forward recursion block.
module hmm_log_forward_multichannel_tb;
    import hlf_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int QUIET_CYCLES   = 40;
    localparam int FILL_STATES    = 4;

    typedef struct packed {
        cmd_t               cmd;
        logic               start;
        logic [3:0]         sym3;
        logic [3:0]         sym2;
        logic [3:0]         sym1;
        logic [3:0]         sym0;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [1:0]         chan;
        logic signed [31:0] val;
    } item_t;

    typedef struct {
        logic [3:0]         state_num;
        logic signed [31:0] alpha;
        logic               last;
    } alpha_beat_t;

    typedef struct {
        item_t it;
        bit    typed;
        int    want;
    } vector_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [IN_TUSER_W-1:0]   s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    int          init_log [16];
    int          trans_log [16][16];
    int          emis_log [4][16][16];
    int          alpha_prev [16];
    int          alpha_count;
    int          states_used;
    int          chans_used;
    int          corr_tab [16] = '{45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950,
                                   1189, 724, 440, 267, 162, 98, 60, 36};
    alpha_beat_t alpha_q [$];
    vector_t     vectors [$];
    int          fails;
    int          beats_seen;
    int          obs_sent;
    int          quiet_cnt = 0;
    bit          calm;
    int          gap_odds;

    hmm_log_forward_multichannel uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d (0x%08h), want %0d (0x%08h)", what, got, got, want, want);
        fails++;
    endtask

    function automatic int sat_sum(input int a, input int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (s < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return int'(s);
    endfunction

    function automatic int pair_lse(input int a, input int b);
        int     hi;
        int     lo;
        longint gap;
        hi  = (a > b) ? a : b;
        lo  = (a > b) ? b : a;
        gap = (longint'(hi) - longint'(lo)) >>> 15;
        if (gap < 16)
        begin
            return sat_sum(hi, corr_tab[gap]);
        end
        return hi;
    endfunction

    task automatic forward_predict(input item_t it);
        int         fresh [16];
        int         acc;
        logic [3:0] syms [4];
        alpha_beat_t b;
        syms = '{it.sym0, it.sym1, it.sym2, it.sym3};
        case (it.cmd)
            CMD_LOAD_INIT:  init_log[it.row] = it.val;
            CMD_LOAD_TRANS: trans_log[it.row][it.col] = it.val;
            CMD_LOAD_EMIS:  emis_log[it.chan][it.row][it.col] = it.val;
            default:
            begin
                obs_sent++;
                for (int i = 0; i < states_used; i++)
                begin
                    if (it.start)
                    begin
                        acc = init_log[i];
                    end
                    else
                    begin
                        acc = sat_sum(alpha_prev[0], trans_log[0][i]);
                        for (int j = 1; j < states_used; j++)
                        begin
                            acc = pair_lse(acc, sat_sum(alpha_prev[j], trans_log[j][i]));
                        end
                    end
                    for (int r = 0; r < chans_used; r++)
                    begin
                        acc = sat_sum(acc, emis_log[r][i][syms[r]]);
                    end
                    fresh[i] = acc;
                end
                for (int i = 0; i < states_used; i++)
                begin
                    alpha_prev[i] = fresh[i];
                    b.state_num   = i[3:0];
                    b.alpha       = fresh[i];
                    b.last        = (i == states_used - 1);
                    alpha_q.push_back(b);
                end
                alpha_count = states_used;
            end
        endcase
    endtask

    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(0, gap_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.val, it.chan, it.col, it.row, it.sym3, it.sym2, it.sym1, it.sym0};
        s_tuser  <= {it.start, it.cmd};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        forward_predict(it);
    endtask

    task automatic write_reg(input logic idx, input int raw);
        int v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= raw;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_STATES)
        begin
            v = raw & 'h1F;
            states_used = (v < 1) ? 1 : (v > 16) ? 16 : v;
        end
        else
        begin
            v = raw & 'h7;
            chans_used = (v < 1) ? 1 : (v > 4) ? 4 : v;
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (alpha_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic int rand_log();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            3:       return 0;
            4:       return -int'($urandom_range(0, 32'h0100_0000));
            default: return -int'($urandom_range(0, 32'h0014_0000));
        endcase
    endfunction

    // observed symbols stay at the two filled extremes, 0 and 15
    function automatic logic [3:0] rand_sym();
        return {4{1'($urandom_range(0, 1))}};
    endfunction

    function automatic item_t rand_item(input cmd_t c, input logic st);
        item_t it;
        it.cmd   = c;
        it.start = st;
        it.sym0  = rand_sym();
        it.sym1  = rand_sym();
        it.sym2  = rand_sym();
        it.sym3  = rand_sym();
        it.row   = 4'($urandom_range(0, 15));
        it.col   = 4'($urandom_range(0, 15));
        it.chan  = 2'($urandom_range(0, 3));
        it.val   = rand_log();
        return it;
    endfunction

    function automatic void add_vec(input cmd_t c, input logic st, input logic [3:0] sym,
                                    input logic [3:0] row, input logic [3:0] col,
                                    input logic [1:0] chan, input int val,
                                    input bit typed, input int want);
        vector_t v;
        v.it       = '0;
        v.it.cmd   = c;
        v.it.start = st;
        v.it.sym0  = sym;
        v.it.sym1  = ~sym;
        v.it.sym2  = sym;
        v.it.sym3  = ~sym;
        v.it.row   = row;
        v.it.col   = col;
        v.it.chan  = chan;
        v.it.val   = val;
        v.typed    = typed;
        v.want     = want;
        vectors.push_back(v);
    endfunction

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cnt <= 0;
        end
        else if (quiet_cnt >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, alpha_q.size());
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial
    begin
        int stall_left;
        alpha_beat_t b;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                beats_seen++;
                if (alpha_q.size() == 0)
                begin
                    report("unexpected beat, state", int'(m_tdata[3:0]), -1);
                end
                else
                begin
                    b = alpha_q.pop_front();
                    if (m_tdata[3:0] != b.state_num)
                    begin
                        report("state_number", int'(m_tdata[3:0]), int'(b.state_num));
                    end
                    if ($signed(m_tdata[35:4]) != b.alpha)
                    begin
                        report("log_alpha", int'(m_tdata[35:4]), int'(b.alpha));
                    end
                    if (m_tlast != b.last)
                    begin
                        report("last", int'(m_tlast), int'(b.last));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rst_n && !calm && $urandom_range(0, gap_odds) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rst_n;
            end
        end
    end

    initial
    begin
        item_t it;
        int    ns_raw [6];
        int    nc_raw [6];
        int    odds [6];
        logic  st;
        ns_raw      = '{4, 0, 31, 3, 17, 4};
        nc_raw      = '{0, 7, 2, 3, 4, 4};
        odds        = '{3, 1, 1000, 4, 2, 0};
        fails       = 0;
        beats_seen  = 0;
        obs_sent    = 0;
        calm        = 1'b0;
        gap_odds    = 3;
        alpha_count = 0;
        states_used = 16;
        chans_used  = 1;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every entry an observation can reach: all initial values, the transitions
        // among the first few states and the emissions of symbols 0 and 15
        for (int i = 0; i < 16; i++)
        begin
            it = rand_item(CMD_LOAD_INIT, 1'b0);
            it.row = 4'(i);
            send_item(it);
        end
        for (int i = 0; i < FILL_STATES; i++)
        begin
            for (int j = 0; j < FILL_STATES; j++)
            begin
                it = rand_item(CMD_LOAD_TRANS, 1'b0);
                it.row = 4'(i);
                it.col = 4'(j);
                send_item(it);
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    it = rand_item(CMD_LOAD_EMIS, 1'b0);
                    it.chan = 2'(r);
                    it.row  = 4'(i);
                    it.col  = {4{1'(s)}};
                    send_item(it);
                end
            end
        end
        drain();
        write_reg(REG_STATES, 1);
        write_reg(REG_CHANNELS, 1);

        add_vec(CMD_LOAD_INIT,  0, 0,  0,  0,  0, 32'h7FFF_FFFF, 0, 0);
        add_vec(CMD_LOAD_EMIS,  0, 0,  0,  15, 0, 32'h7FFF_FFFF, 0, 0);
        add_vec(CMD_OBSERVE,    1, 15, 0,  0,  0, 0, 1, 32'h7FFF_FFFF);
        add_vec(CMD_LOAD_INIT,  0, 0,  0,  0,  0, 32'h8000_0000, 0, 0);
        add_vec(CMD_LOAD_EMIS,  0, 0,  0,  0,  0, 32'h8000_0000, 0, 0);
        add_vec(CMD_OBSERVE,    1, 0,  0,  0,  0, 0, 1, 32'h8000_0000);
        add_vec(CMD_OBSERVE,    0, 0,  15, 15, 3, 0, 0, 0);
        add_vec(CMD_LOAD_INIT,  0, 0,  0,  0,  0, 32'h8000_0000, 0, 0);
        add_vec(CMD_OBSERVE,    1, 0,  0,  0,  0, 0, 1, 32'h8000_0000);
        add_vec(CMD_LOAD_TRANS, 0, 0,  0,  0,  0, 0, 0, 0);
        add_vec(CMD_LOAD_EMIS,  0, 0,  0,  5,  0, 0, 0, 0);
        add_vec(CMD_OBSERVE,    0, 5,  0,  0,  0, 0, 1, 32'h8000_0000);
        add_vec(CMD_LOAD_INIT,  0, 0,  0,  0,  0, 32'h0001_0000, 0, 0);
        add_vec(CMD_LOAD_EMIS,  0, 0,  0,  10, 0, 32'hFFFF_0000, 0, 0);
        add_vec(CMD_OBSERVE,    1, 10, 0,  0,  0, 0, 1, 0);
        add_vec(CMD_LOAD_TRANS, 0, 0,  15, 15, 0, 32'h8000_0000, 0, 0);
        add_vec(CMD_LOAD_EMIS,  0, 0,  15, 15, 3, 32'h7FFF_FFFF, 0, 0);
        add_vec(CMD_LOAD_INIT,  0, 0,  15, 0,  0, 32'h5555_AAAA, 0, 0);
        add_vec(CMD_LOAD_TRANS, 0, 0,  0,  0,  0, 32'hFFF8_0000, 0, 0);
        add_vec(CMD_OBSERVE,    0, 10, 0,  0,  0, 0, 0, 0);
        add_vec(CMD_OBSERVE,    0, 15, 0,  0,  0, 0, 0, 0);
        foreach (vectors[k])
        begin
            send_item(vectors[k].it);
            if (vectors[k].typed)
            begin
                alpha_q[$].alpha = vectors[k].want;
            end
        end
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_STATES, ns_raw[p]);
            write_reg(REG_CHANNELS, nc_raw[p]);
            gap_odds = odds[p];
            calm     = (p == 5);
            for (int n = 0; n < 20; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    st = (states_used > FILL_STATES) || ($urandom_range(0, 5) == 0)
                         || (alpha_count < states_used);
                    send_item(rand_item(CMD_OBSERVE, st));
                end
                else
                begin
                    send_item(rand_item(cmd_t'($urandom_range(1, 3)), 1'b0));
                end
            end
            drain();
        end

        $display("covered %0d observations and %0d result beats over six register settings",
                 obs_sent, beats_seen);
        $display("table loads, saturation extremes and back-pressure on both sides included");
        if (fails == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
